// ----- src/pgs_pkg.sv -----
// Shared types and codes for the portamento glide slew unit.
package pgs_pkg;

    localparam int PITCH_W = 32;
    localparam int COEFF_W = 16;
    localparam int MODE_W  = 2;
    localparam int CMD_W   = 2;

    // request commands
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_TARGET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SNAP       = 2'd2;

    // glide modes
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LEGATO = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_COEFF  = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;

    typedef struct packed {
        logic [COEFF_W-1:0] coeff;
        logic [MODE_W-1:0]  mode;
        logic [PITCH_W-1:0] thresh;
    } t_cfg;

    typedef struct packed {
        logic [PITCH_W-1:0] cur;
        logic [PITCH_W-1:0] tgt;
        logic               glide;
    } t_voice;

endpackage

// ----- src/portamento_glide_slew_unit.sv -----
// Top level of the portamento glide slew unit: request/result channels and registers.
//
// Usage: requests enter on the in channel (i_in_valid / o_in_stall) with i_cmd,
// i_pitch, i_legato and i_arp_active. A tick request returns one result on the
// out channel (o_out_valid / i_out_stall) carrying o_pitch_out; set-target and
// snap requests update the voice state and return nothing; cmd 3 is ignored.
// A request is registered at acceptance and evaluated against the voice
// state; a tick result enters the result register when the request advances.
// One request is taken per cycle unless a tick waits on a stalled result; the
// one-pole step is a single 16x32 multiply followed by an add or subtract, and
// it also updates the voice state so back-to-back ticks see each other's result.
// If the receiver stalls, the result register holds; a tick waiting behind it
// stalls the input, while set-target and snap requests still pass.
// Reset (synchronous, active low) clears the voice to pitch 0 with glide off,
// clears all registers and empties both stages. Registers sit on an APB port at
// byte addresses 0 (coefficient), 4 (glide mode) and 8 (snap threshold); write
// them only while no request is in flight.
module portamento_glide_slew_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [pgs_pkg::CMD_W-1:0]   i_cmd,
    input  logic [pgs_pkg::PITCH_W-1:0] i_pitch,
    input  logic                        i_legato,
    input  logic                        i_arp_active,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [pgs_pkg::PITCH_W-1:0] o_pitch_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pgs_pkg::*;

    t_cfg               r_cfg;
    t_voice             r_voice;
    t_voice             n_voice;
    logic               r_in_valid;
    logic [CMD_W-1:0]   r_cmd;
    logic [PITCH_W-1:0] r_pitch;
    logic               r_legato;
    logic               r_arp;
    logic               r_out_valid;
    logic [PITCH_W-1:0] r_out_pitch;
    logic [PITCH_W-1:0] tick_pitch;
    logic               advance;
    logic               in_take;
    logic               cfg_wr;

    // a tick needs the result register free; other commands never wait
    assign advance = r_in_valid &&
                     ((r_cmd != CMD_TICK) || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_pitch_out = r_out_pitch;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    pgs_step u_step (
        .i_cmd        (r_cmd),
        .i_pitch      (r_pitch),
        .i_legato     (r_legato),
        .i_arp_active (r_arp),
        .i_cfg        (r_cfg),
        .i_voice      (r_voice),
        .o_voice      (n_voice),
        .o_tick_pitch (tick_pitch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_voice     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_voice <= n_voice;
            end
            if (advance && (r_cmd == CMD_TICK)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd    <= i_cmd;
            r_pitch  <= i_pitch;
            r_legato <= i_legato;
            r_arp    <= i_arp_active;
        end
        if (advance && (r_cmd == CMD_TICK)) begin
            r_out_pitch <= tick_pitch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_COEFF:  r_cfg.coeff  <= pwdata[COEFF_W-1:0];
                REG_MODE:   r_cfg.mode   <= pwdata[MODE_W-1:0];
                REG_THRESH: r_cfg.thresh <= pwdata[PITCH_W-1:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_COEFF:  prdata = {{(32-COEFF_W){1'b0}}, r_cfg.coeff};
            REG_MODE:   prdata = {{(32-MODE_W){1'b0}}, r_cfg.mode};
            REG_THRESH: prdata = r_cfg.thresh;
            default:    prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_snap_stops_glide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_cmd == CMD_SNAP)
        |=> !r_voice.glide && (r_voice.cur == r_voice.tgt))
        else $error("snap left glide running or pitches apart");

    a_arp_no_glide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_cmd == CMD_SET_TARGET) && r_arp
        |=> !r_voice.glide && (r_voice.cur == r_voice.tgt))
        else $error("target with arpeggiator did not jump");

    a_idle_tick_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_cmd == CMD_TICK) && !r_voice.glide
        |=> o_out_valid && (o_pitch_out == $past(r_voice.tgt)))
        else $error("tick without glide missed the target");

    a_tick_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_cmd == CMD_TICK)
        |=> (($past(r_voice.cur) <= $past(r_voice.tgt)) &&
             (o_pitch_out >= $past(r_voice.cur)) && (o_pitch_out <= $past(r_voice.tgt))) ||
            (($past(r_voice.cur) > $past(r_voice.tgt)) &&
             (o_pitch_out <= $past(r_voice.cur)) && (o_pitch_out >= $past(r_voice.tgt))))
        else $error("tick left the span between current and target");
`endif

endmodule

// ----- src/pgs_step.sv -----
// Next-state and tick-result logic for one request of the glide unit.
module pgs_step (
    input  logic [pgs_pkg::CMD_W-1:0]   i_cmd,
    input  logic [pgs_pkg::PITCH_W-1:0] i_pitch,
    input  logic                        i_legato,
    input  logic                        i_arp_active,
    input  pgs_pkg::t_cfg               i_cfg,
    input  pgs_pkg::t_voice             i_voice,
    output pgs_pkg::t_voice             o_voice,
    output logic [pgs_pkg::PITCH_W-1:0] o_tick_pitch
);
    import pgs_pkg::*;

    logic                       rising;
    logic [PITCH_W-1:0]         mag;
    logic                       land;
    logic [PITCH_W+COEFF_W-1:0] prod;
    logic [PITCH_W-1:0]         q_dn;
    logic [PITCH_W:0]           q_up;
    logic                       set_glide;

    always_comb begin
        rising = (i_voice.tgt >= i_voice.cur);
        mag    = rising ? (i_voice.tgt - i_voice.cur) : (i_voice.cur - i_voice.tgt);
        land   = !i_voice.glide || (i_cfg.coeff == '0) || (mag <= i_cfg.thresh);
        prod   = (PITCH_W+COEFF_W)'(i_cfg.coeff) * (PITCH_W+COEFF_W)'(mag);
        q_dn   = prod[PITCH_W+COEFF_W-1:COEFF_W];
        // falling glide: floor of a negative step rounds the magnitude up
        q_up   = {1'b0, q_dn} + (PITCH_W+1)'(prod[COEFF_W-1:0] != '0);

        if (land) begin
            o_tick_pitch = i_voice.tgt;
        end else if (rising) begin
            o_tick_pitch = i_voice.tgt - q_dn;
        end else begin
            o_tick_pitch = i_voice.tgt + q_up[PITCH_W-1:0];
        end

        set_glide = !i_arp_active &&
                    ((i_cfg.mode == MODE_ON) || ((i_cfg.mode == MODE_LEGATO) && i_legato));

        o_voice = i_voice;
        unique case (i_cmd)
            CMD_TICK: begin
                o_voice.cur = o_tick_pitch;
            end
            CMD_SET_TARGET: begin
                o_voice.tgt   = i_pitch;
                o_voice.glide = set_glide;
                if (!set_glide) begin
                    o_voice.cur = i_pitch;
                end
            end
            CMD_SNAP: begin
                o_voice.cur   = i_pitch;
                o_voice.tgt   = i_pitch;
                o_voice.glide = 1'b0;
            end
            default: begin
                o_voice = i_voice;
            end
        endcase
    end

endmodule
